### hdl/pgr_pkg.sv
// Shared types and constants of the polyline grid rasterizer.
`default_nettype none

package pgr_pkg;

   localparam int COORD_W       = 6;
   localparam int DATA_W        = 16;
   localparam int GRID_SIZE_DEF = 64;
   localparam int ERR_W         = COORD_W + 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } line_ctl_type;

   typedef struct packed {
      logic last_step;
   } line_stat_type;

endpackage

`default_nettype wire

### hdl/pgr_line_unit.sv
// Bresenham step unit: holds the current point and error term, advances one point a cycle while its step input is set.
`default_nettype none

module pgr_line_unit
   import pgr_pkg::*;
(
   input  wire logic               clock,
   input  wire line_ctl_type       ctl,
   input  wire logic [COORD_W-1:0] start_x,
   input  wire logic [COORD_W-1:0] start_y,
   input  wire logic [COORD_W-1:0] end_x,
   input  wire logic [COORD_W-1:0] end_y,
   output logic [COORD_W-1:0]      cur_x,
   output logic [COORD_W-1:0]      cur_y,
   output line_stat_type           stat
);

   logic [COORD_W-1:0]      cx_ff, cx_in, cy_ff, cy_in;
   logic [COORD_W-1:0]      ex_ff, ex_in, ey_ff, ey_in;
   logic [COORD_W-1:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic                    sx_ff, sx_in, sy_ff, sy_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [ERR_W:0]   e2;
   logic signed [ERR_W:0]   dx_s;
   logic signed [ERR_W:0]   dy_s;
   logic                    mov_x;
   logic                    mov_y;
   logic [COORD_W-1:0]      nx;
   logic [COORD_W-1:0]      ny;
   logic [COORD_W-1:0]      ld_dx;
   logic [COORD_W-1:0]      ld_dy;

   always_comb begin
      ld_dx = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
      ld_dy = (end_y >= start_y) ? end_y - start_y : start_y - end_y;

      // The error term is doubled and compared against -dy and dx.
      e2    = {err_ff, 1'b0};
      dx_s  = signed'({3'b000, dx_ff});
      dy_s  = signed'({3'b000, dy_ff});
      mov_x = e2 > -dy_s;
      mov_y = e2 < dx_s;

      nx = cx_ff;
      ny = cy_ff;
      if (mov_x) begin
         nx = sx_ff ? cx_ff + COORD_W'(1) : cx_ff - COORD_W'(1);
      end
      if (mov_y) begin
         ny = sy_ff ? cy_ff + COORD_W'(1) : cy_ff - COORD_W'(1);
      end

      cx_in  = cx_ff;
      cy_in  = cy_ff;
      ex_in  = ex_ff;
      ey_in  = ey_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      err_in = err_ff;

      if (ctl.load) begin
         cx_in  = start_x;
         cy_in  = start_y;
         ex_in  = end_x;
         ey_in  = end_y;
         dx_in  = ld_dx;
         dy_in  = ld_dy;
         sx_in  = start_x < end_x;
         sy_in  = start_y < end_y;
         err_in = signed'({2'b00, ld_dx}) - signed'({2'b00, ld_dy});
      end else if (ctl.step) begin
         cx_in  = nx;
         cy_in  = ny;
         err_in = err_ff - (mov_x ? signed'({2'b00, dy_ff}) : ERR_W'(0))
                         + (mov_y ? signed'({2'b00, dx_ff}) : ERR_W'(0));
      end
   end

   always_ff @(posedge clock) begin
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      ex_ff  <= ex_in;
      ey_ff  <= ey_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      err_ff <= err_in;
   end

   assign cur_x          = cx_ff;
   assign cur_y          = cy_ff;
   assign stat.last_step = (nx == ex_ff) && (ny == ey_ff);

endmodule

`default_nettype wire

### hdl/polyline_grid_rasterizer_top.sv
// Top level of the polyline grid rasterizer: waypoint sequencer and output word register.
`default_nettype none

// Channel   Dir  Word contents
// req_      in   tdata[5:0] waypoint_x, tdata[11:6] waypoint_y, tlast final_waypoint
// rsp_      out  tdata[5:0] point_x, tdata[11:6] point_y, tuser run_last, tlast path_end
//
// A waypoint is accepted while the sequencer is idle. The single Bresenham step
// unit then walks the segment one grid point at a time, and a final waypoint
// adds the end point of the path; no waypoint is accepted during the walk.
// Reset is synchronous and active high and clears the held waypoint and the output.
// A stalled output holds the step unit; the next waypoint is taken while the last
// point still waits in the output register.

module polyline_grid_rasterizer_top
   import pgr_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,  // waypoint_x, waypoint_y, zero fill
   input  wire logic              req_tlast,  // final_waypoint
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,  // point_x, point_y, zero fill
   output logic                   rsp_tuser,  // run_last
   output logic                   rsp_tlast   // path_end
);

   localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(GRID_SIZE - 1);

   state_type          state_ff, state_in;
   logic               have_prev_ff, have_prev_in;
   logic [COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [COORD_W-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic               fin_ff, fin_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_end_ff, rsp_end_in;

   logic               accept;
   logic               slot_free;
   logic [COORD_W-1:0] in_x;
   logic [COORD_W-1:0] in_y;
   logic [COORD_W-1:0] raw_x;
   logic [COORD_W-1:0] raw_y;
   line_ctl_type       line_ctl;
   line_stat_type      line_stat;
   logic [COORD_W-1:0] cur_x;
   logic [COORD_W-1:0] cur_y;

   pgr_line_unit u_line (
      .clock   (clock),
      .ctl     (line_ctl),
      .start_x (prev_x_ff),
      .start_y (prev_y_ff),
      .end_x   (in_x),
      .end_y   (in_y),
      .cur_x   (cur_x),
      .cur_y   (cur_y),
      .stat    (line_stat)
   );

   always_comb begin
      // Coordinates past the grid edge are pinned to the last column or row.
      raw_x = req_tdata[COORD_W-1:0];
      raw_y = req_tdata[2*COORD_W-1:COORD_W];
      in_x  = (raw_x > MAX_COORD) ? MAX_COORD : raw_x;
      in_y  = (raw_y > MAX_COORD) ? MAX_COORD : raw_y;

      req_tready = (state_ff == ST_IDLE);
      accept     = req_tvalid && req_tready;
      slot_free  = !rsp_valid_ff || rsp_tready;

      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      line_ctl     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!have_prev_ff) begin
                  // First waypoint of a path is only remembered, unless it is also the final one.
                  if (!req_tlast) begin
                     have_prev_in = 1'b1;
                     prev_x_in    = in_x;
                     prev_y_in    = in_y;
                  end
               end else begin
                  line_ctl.load = 1'b1;
                  tgt_x_in      = in_x;
                  tgt_y_in      = in_y;
                  fin_in        = req_tlast;
                  if (req_tlast) begin
                     have_prev_in = 1'b0;
                     prev_x_in    = '0;
                     prev_y_in    = '0;
                  end else begin
                     prev_x_in = in_x;
                     prev_y_in = in_y;
                  end
                  if ((prev_x_ff != in_x) || (prev_y_ff != in_y)) begin
                     state_in = ST_RUN;
                  end else if (req_tlast) begin
                     state_in = ST_FINAL;
                  end
               end
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               line_ctl.step = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_x_in      = cur_x;
               rsp_y_in      = cur_y;
               rsp_end_in    = 1'b0;
               rsp_last_in   = line_stat.last_step && !fin_ff;
               if (line_stat.last_step) begin
                  state_in = fin_ff ? ST_FINAL : ST_IDLE;
               end
            end
         end
         ST_FINAL: begin
            // The end point of the path closes both the run and the path.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = tgt_x_ff;
               rsp_y_in     = tgt_y_ff;
               rsp_last_in  = 1'b1;
               rsp_end_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_x_ff    <= tgt_x_in;
      tgt_y_ff    <= tgt_y_in;
      fin_ff      <= fin_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(DATA_W - 2*COORD_W)'(0), rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_last_ff;
   assign rsp_tlast  = rsp_end_ff;

endmodule

`default_nettype wire
